// ===== rtl/sdbts_pkg.sv =====
// ----------------------------------------------------------------------------
// sdbts_pkg
// Types and codes shared by the sd block transfer sequencer files: request,
// command, flag, result and status codes, and the item and config structs.
// ----------------------------------------------------------------------------
package sdbts_pkg;

   // field widths fixed by the interface
   localparam int POS_W   = 41;
   localparam int LEN_W   = 16;
   localparam int ARG_W   = 32;
   localparam int IDX_W   = 6;
   localparam int FLAG_W  = 7;
   localparam int RCA_W   = 16;
   localparam int CNT_W   = 32;
   localparam int CSR_A_W = 3;

   // sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE   = 3'd0,
      SEQ_STATUS = 3'd1,
      SEQ_SELECT = 3'd2,
      SEQ_XFER   = 3'd3,
      SEQ_HALT   = 3'd4,
      SEQ_ERROR  = 3'd5
   } seq_state_type;

   // request codes
   localparam logic [2:0] REQ_SET_POS    = 3'd0;
   localparam logic [2:0] REQ_READ       = 3'd1;
   localparam logic [2:0] REQ_WRITE      = 3'd2;
   localparam logic [2:0] REQ_COMPLETE   = 3'd3;
   localparam logic [2:0] REQ_ISSUE_FAIL = 3'd4;

   // command numbers
   localparam logic [IDX_W-1:0] CMD_NONE         = 6'd0;
   localparam logic [IDX_W-1:0] CMD_SELECT       = 6'd7;
   localparam logic [IDX_W-1:0] CMD_STOP         = 6'd12;
   localparam logic [IDX_W-1:0] CMD_STATUS       = 6'd13;
   localparam logic [IDX_W-1:0] CMD_READ_SINGLE  = 6'd17;
   localparam logic [IDX_W-1:0] CMD_READ_MULTI   = 6'd18;
   localparam logic [IDX_W-1:0] CMD_WRITE_SINGLE = 6'd24;
   localparam logic [IDX_W-1:0] CMD_WRITE_MULTI  = 6'd25;

   // command flags
   localparam logic [FLAG_W-1:0] FLAG_DATA     = 7'h01;
   localparam logic [FLAG_W-1:0] FLAG_WRITE    = 7'h02;
   localparam logic [FLAG_W-1:0] FLAG_AUTOSTOP = 7'h04;
   localparam logic [FLAG_W-1:0] FLAG_STOP     = 7'h08;
   localparam logic [FLAG_W-1:0] FLAG_CRC      = 7'h10;
   localparam logic [FLAG_W-1:0] FLAG_WAITDATA = 7'h20;
   localparam logic [FLAG_W-1:0] FLAG_SHORT    = 7'h40;

   // request result codes
   localparam logic [1:0] RES_ACCEPTED = 2'd0;
   localparam logic [1:0] RES_REJECTED = 2'd1;
   localparam logic [1:0] RES_ZERO_LEN = 2'd2;
   localparam logic [1:0] RES_NOT_REQ  = 2'd3;

   // reported status
   localparam logic [1:0] STAT_IDLE  = 2'd0;
   localparam logic [1:0] STAT_BUSY  = 2'd1;
   localparam logic [1:0] STAT_ERROR = 2'd2;

   // r1 current-state codes
   localparam logic [3:0] R1_STBY = 4'd3;
   localparam logic [3:0] R1_TRAN = 4'd4;

   // csr register indexes
   localparam logic [CSR_A_W-1:0] CSR_CARD_ADDRESS  = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_HIGH_CAPACITY = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_CRC_ENABLE    = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_SPI_MODE      = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_BLOCK_COUNT   = 3'd4;

   typedef struct packed {
      logic [2:0]       req_type;
      logic [POS_W-1:0] byte_position;
      logic [LEN_W-1:0] length_blocks;
      logic             if_ok;
      logic [3:0]       card_state;
   } req_item_type;

   typedef struct packed {
      logic [RCA_W-1:0] card_address;
      logic             high_capacity;
      logic             crc_enable;
      logic             spi_mode;
      logic [CNT_W-1:0] block_count;
   } cfg_type;

   typedef struct packed {
      logic              cmd_valid;
      logic [IDX_W-1:0]  cmd_index;
      logic [ARG_W-1:0]  cmd_argument;
      logic [FLAG_W-1:0] cmd_flags;
      logic [LEN_W-1:0]  xfer_blocks;
      logic [1:0]        req_result;
      logic              done_event;
      logic [1:0]        status;
   } rsp_item_type;

endpackage

// ===== rtl/sdbts_seq.sv =====
// ----------------------------------------------------------------------------
// sdbts_seq
// Sequencer state and step logic: takes one registered item per enabled
// cycle, updates position, pending data command and state, and forms the
// result item combinationally.
// ----------------------------------------------------------------------------
module sdbts_seq #(
   parameter int BLOCK_SHIFT = 9,
   parameter int MAX_BLOCKS  = 65535
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  sdbts_pkg::req_item_type item,
   input  sdbts_pkg::cfg_type      cfg,
   output sdbts_pkg::rsp_item_type rsp
);

   sdbts_pkg::seq_state_type state_ff, state_in;
   logic [sdbts_pkg::POS_W-1:0]  cur_position_ff, cur_position_in;
   logic [sdbts_pkg::IDX_W-1:0]  pend_index_ff, pend_index_in;
   logic [sdbts_pkg::ARG_W-1:0]  pend_argument_ff, pend_argument_in;
   logic [sdbts_pkg::FLAG_W-1:0] pend_flags_ff, pend_flags_in;
   logic [sdbts_pkg::LEN_W-1:0]  pend_blocks_ff, pend_blocks_in;

   logic                         busy;
   logic                         pos_ok;
   logic                         too_long;
   logic                         xfer_start;
   logic                         is_write;
   logic [sdbts_pkg::POS_W-1:0]  blk_pos;
   logic [sdbts_pkg::IDX_W-1:0]  data_index;
   logic [sdbts_pkg::ARG_W-1:0]  data_argument;
   logic [sdbts_pkg::FLAG_W-1:0] data_flags;
   logic [sdbts_pkg::FLAG_W-1:0] crc_flag;
   logic [sdbts_pkg::ARG_W-1:0]  rca_arg;
   logic                         card_in_xfer;
   logic                         card_in_standby;

   // shared decode
   assign busy     = (state_ff != sdbts_pkg::SEQ_IDLE) && (state_ff != sdbts_pkg::SEQ_ERROR);
   assign pos_ok   = (item.byte_position[BLOCK_SHIFT-1:0] == '0) &&
                     ((item.byte_position >> BLOCK_SHIFT) <
                      sdbts_pkg::POS_W'(cfg.block_count));
   assign too_long = 32'(item.length_blocks) > 32'(MAX_BLOCKS);
   assign is_write = item.req_type == sdbts_pkg::REQ_WRITE;
   assign xfer_start = ((item.req_type == sdbts_pkg::REQ_READ) || is_write) &&
                       (item.length_blocks != '0) && !busy && !too_long;
   assign crc_flag = cfg.crc_enable ? sdbts_pkg::FLAG_CRC : '0;
   assign rca_arg  = {cfg.card_address, 16'h0000};
   assign card_in_xfer    = item.if_ok && (item.card_state == sdbts_pkg::R1_TRAN);
   assign card_in_standby = item.if_ok && (item.card_state == sdbts_pkg::R1_STBY);

   // data command built from the current position
   assign blk_pos       = cur_position_ff >> BLOCK_SHIFT;
   assign data_argument = cfg.high_capacity ? blk_pos[sdbts_pkg::ARG_W-1:0]
                                            : cur_position_ff[sdbts_pkg::ARG_W-1:0];
   always_comb begin
      logic multi;
      multi = item.length_blocks != 16'd1;
      if (is_write) begin
         data_index = multi ? sdbts_pkg::CMD_WRITE_MULTI : sdbts_pkg::CMD_WRITE_SINGLE;
      end else begin
         data_index = multi ? sdbts_pkg::CMD_READ_MULTI : sdbts_pkg::CMD_READ_SINGLE;
      end
      data_flags = sdbts_pkg::FLAG_DATA | crc_flag;
      if (is_write) data_flags = data_flags | sdbts_pkg::FLAG_WRITE;
      if (multi) data_flags = data_flags | sdbts_pkg::FLAG_AUTOSTOP;
      if (!cfg.spi_mode) data_flags = data_flags | sdbts_pkg::FLAG_SHORT;
   end

   // next state
   always_comb begin
      state_in         = state_ff;
      cur_position_in  = cur_position_ff;
      pend_index_in    = pend_index_ff;
      pend_argument_in = pend_argument_ff;
      pend_flags_in    = pend_flags_ff;
      pend_blocks_in   = pend_blocks_ff;
      unique case (item.req_type)
         sdbts_pkg::REQ_SET_POS: begin
            if (pos_ok) cur_position_in = item.byte_position;
         end
         sdbts_pkg::REQ_READ, sdbts_pkg::REQ_WRITE: begin
            if (xfer_start) begin
               pend_index_in    = data_index;
               pend_argument_in = data_argument;
               pend_flags_in    = data_flags;
               pend_blocks_in   = item.length_blocks;
               state_in = cfg.spi_mode ? sdbts_pkg::SEQ_XFER : sdbts_pkg::SEQ_STATUS;
            end
         end
         sdbts_pkg::REQ_COMPLETE: begin
            unique case (state_ff)
               sdbts_pkg::SEQ_STATUS: begin
                  if (card_in_xfer) state_in = sdbts_pkg::SEQ_XFER;
                  else if (card_in_standby) state_in = sdbts_pkg::SEQ_SELECT;
                  else state_in = sdbts_pkg::SEQ_ERROR;
               end
               sdbts_pkg::SEQ_SELECT: state_in = sdbts_pkg::SEQ_XFER;
               sdbts_pkg::SEQ_XFER: begin
                  state_in = item.if_ok ? sdbts_pkg::SEQ_IDLE : sdbts_pkg::SEQ_HALT;
               end
               sdbts_pkg::SEQ_HALT: state_in = sdbts_pkg::SEQ_ERROR;
               default: state_in = state_ff;
            endcase
         end
         sdbts_pkg::REQ_ISSUE_FAIL: begin
            if (busy) state_in = sdbts_pkg::SEQ_ERROR;
         end
         default: state_in = state_ff;
      endcase
   end

   // result item
   always_comb begin
      rsp = '0;
      rsp.req_result = sdbts_pkg::RES_NOT_REQ;
      unique case (item.req_type)
         sdbts_pkg::REQ_SET_POS: begin
            rsp.req_result = pos_ok ? sdbts_pkg::RES_ACCEPTED : sdbts_pkg::RES_REJECTED;
         end
         sdbts_pkg::REQ_READ, sdbts_pkg::REQ_WRITE: begin
            if (item.length_blocks == '0) begin
               rsp.req_result = sdbts_pkg::RES_ZERO_LEN;
            end else if (!xfer_start) begin
               rsp.req_result = sdbts_pkg::RES_REJECTED;
            end else begin
               rsp.req_result = sdbts_pkg::RES_ACCEPTED;
               rsp.cmd_valid  = 1'b1;
               if (!cfg.spi_mode) begin
                  rsp.cmd_index    = sdbts_pkg::CMD_STATUS;
                  rsp.cmd_argument = rca_arg;
                  rsp.cmd_flags    = sdbts_pkg::FLAG_WAITDATA | crc_flag |
                                     sdbts_pkg::FLAG_SHORT;
               end else begin
                  rsp.cmd_index    = data_index;
                  rsp.cmd_argument = data_argument;
                  rsp.cmd_flags    = data_flags;
                  rsp.xfer_blocks  = item.length_blocks;
               end
            end
         end
         sdbts_pkg::REQ_COMPLETE: begin
            unique case (state_ff)
               sdbts_pkg::SEQ_STATUS: begin
                  if (card_in_xfer) begin
                     rsp.cmd_valid    = 1'b1;
                     rsp.cmd_index    = pend_index_ff;
                     rsp.cmd_argument = pend_argument_ff;
                     rsp.cmd_flags    = pend_flags_ff;
                     rsp.xfer_blocks  = pend_blocks_ff;
                  end else if (card_in_standby) begin
                     rsp.cmd_valid    = 1'b1;
                     rsp.cmd_index    = sdbts_pkg::CMD_SELECT;
                     rsp.cmd_argument = rca_arg;
                     rsp.cmd_flags    = sdbts_pkg::FLAG_WAITDATA | crc_flag |
                                        sdbts_pkg::FLAG_SHORT;
                  end else begin
                     rsp.done_event = 1'b1;
                  end
               end
               sdbts_pkg::SEQ_SELECT: begin
                  rsp.cmd_valid    = 1'b1;
                  rsp.cmd_index    = pend_index_ff;
                  rsp.cmd_argument = pend_argument_ff;
                  rsp.cmd_flags    = pend_flags_ff;
                  rsp.xfer_blocks  = pend_blocks_ff;
               end
               sdbts_pkg::SEQ_XFER: begin
                  if (item.if_ok) begin
                     rsp.done_event = 1'b1;
                  end else begin
                     rsp.cmd_valid = 1'b1;
                     rsp.cmd_index = sdbts_pkg::CMD_STOP;
                     rsp.cmd_flags = sdbts_pkg::FLAG_STOP | crc_flag | sdbts_pkg::FLAG_SHORT;
                  end
               end
               sdbts_pkg::SEQ_HALT: rsp.done_event = 1'b1;
               default: rsp.done_event = 1'b0;
            endcase
         end
         sdbts_pkg::REQ_ISSUE_FAIL: rsp.done_event = busy;
         default: rsp.req_result = sdbts_pkg::RES_NOT_REQ;
      endcase
      // status after this step
      if (state_in == sdbts_pkg::SEQ_IDLE) rsp.status = sdbts_pkg::STAT_IDLE;
      else if (state_in == sdbts_pkg::SEQ_ERROR) rsp.status = sdbts_pkg::STAT_ERROR;
      else rsp.status = sdbts_pkg::STAT_BUSY;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sdbts_pkg::SEQ_IDLE;
         cur_position_ff  <= '0;
         pend_index_ff    <= '0;
         pend_argument_ff <= '0;
         pend_flags_ff    <= '0;
         pend_blocks_ff   <= '0;
      end else if (step_en) begin
         state_ff         <= state_in;
         cur_position_ff  <= cur_position_in;
         pend_index_ff    <= pend_index_in;
         pend_argument_ff <= pend_argument_in;
         pend_flags_ff    <= pend_flags_in;
         pend_blocks_ff   <= pend_blocks_in;
      end
   end

endmodule

// ===== rtl/sd_block_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// sd_block_transfer_sequencer
// Path: an accepted request loads the input register; the sequencer step then
// forms its result item, which loads the result register when the step advances.
// Throughput: one item per cycle while rsp_stall is low; each step updates the
// single state register, so back-to-back items see the previous step's state.
// Reset: synchronous, active high; sequencer idle, position and csrs zero.
// ----------------------------------------------------------------------------
module sd_block_transfer_sequencer #(
   parameter int BLOCK_SHIFT = 9,
   parameter int MAX_BLOCKS  = 65535
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [40:0] req_byte_position,
   input  logic [15:0] req_length_blocks,
   input  logic        req_if_ok,
   input  logic [3:0]  req_card_state,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_cmd_valid,
   output logic [5:0]  rsp_cmd_index,
   output logic [31:0] rsp_cmd_argument,
   output logic [6:0]  rsp_cmd_flags,
   output logic [15:0] rsp_xfer_blocks,
   output logic [1:0]  rsp_req_result,
   output logic        rsp_done_event,
   output logic [1:0]  rsp_status
);

   sdbts_pkg::cfg_type      cfg_ff;
   sdbts_pkg::req_item_type in_ff;
   sdbts_pkg::rsp_item_type out_ff, step_rsp;
   logic                    in_valid_ff, in_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    req_accept;
   logic                    advance;

   // handshake
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sdbts_pkg::CSR_CARD_ADDRESS:  cfg_ff.card_address  <= csr_wdata[15:0];
            sdbts_pkg::CSR_HIGH_CAPACITY: cfg_ff.high_capacity <= csr_wdata[0];
            sdbts_pkg::CSR_CRC_ENABLE:    cfg_ff.crc_enable    <= csr_wdata[0];
            sdbts_pkg::CSR_SPI_MODE:      cfg_ff.spi_mode      <= csr_wdata[0];
            sdbts_pkg::CSR_BLOCK_COUNT:   cfg_ff.block_count   <= csr_wdata;
            default:                      cfg_ff <= cfg_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff.req_type      <= req_type;
         in_ff.byte_position <= req_byte_position;
         in_ff.length_blocks <= req_length_blocks;
         in_ff.if_ok         <= req_if_ok;
         in_ff.card_state    <= req_card_state;
      end
   end

   // sequencer step
   sdbts_seq #(
      .BLOCK_SHIFT(BLOCK_SHIFT),
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_seq (
      .clock  (clock),
      .reset  (reset),
      .step_en(advance),
      .item   (in_ff),
      .cfg    (cfg_ff),
      .rsp    (step_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (advance) out_ff <= step_rsp;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_cmd_valid    = out_ff.cmd_valid;
   assign rsp_cmd_index    = out_ff.cmd_index;
   assign rsp_cmd_argument = out_ff.cmd_argument;
   assign rsp_cmd_flags    = out_ff.cmd_flags;
   assign rsp_xfer_blocks  = out_ff.xfer_blocks;
   assign rsp_req_result   = out_ff.req_result;
   assign rsp_done_event   = out_ff.done_event;
   assign rsp_status       = out_ff.status;

   // checks
   a_stall_only_when_holding : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with an empty input register");

   a_step_lands_in_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("sequencer step did not produce a result");

   a_done_not_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_event |-> rsp_status != sdbts_pkg::STAT_BUSY)
      else $error("done reported while still busy");

   a_no_cmd_fields_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_cmd_valid |-> rsp_cmd_index == sdbts_pkg::CMD_NONE &&
                                      rsp_xfer_blocks == '0 && rsp_cmd_flags == '0)
      else $error("command fields set without a command");

endmodule

// ===== tb/sv/sd_block_transfer_sequencer_test.sv =====
// ----------------------------------------------------------------------------
// sd_block_transfer_sequencer_test
// Self-checking bench for the sd block transfer sequencer. A queue of request
// items (directed corner cases, then well-formed transfer scripts mixed with
// noise) feeds a clocked driver; each accepted item advances a shadow
// sequencer that predicts the result item, and a clocked monitor compares
// every result field by field. Settings change between phases while idle.
// ----------------------------------------------------------------------------
module sd_block_transfer_sequencer_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int BLK_SHIFT    = 9;
   localparam int MAX_BLK      = 65535;
   localparam int PHASE_ITEMS  = 125;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE       = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sdbts_pkg::req_item_type req_drive = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_cmd_valid;
   logic [5:0]  rsp_cmd_index;
   logic [31:0] rsp_cmd_argument;
   logic [6:0]  rsp_cmd_flags;
   logic [15:0] rsp_xfer_blocks;
   logic [1:0]  rsp_req_result;
   logic        rsp_done_event;
   logic [1:0]  rsp_status;

   // pending request items and predicted result items
   sdbts_pkg::req_item_type req_backlog[$];
   sdbts_pkg::rsp_item_type seq_outcomes[$];
   int items_queued   = 0;
   int items_accepted = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;

   // idling and receiver hold-off control
   int send_gap_pct  = 15;
   int stall_pct     = 15;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   // shadow settings and sequencer state
   sdbts_pkg::cfg_type                  cfg_shadow  = '0;
   sdbts_pkg::seq_state_type            seq_now     = sdbts_pkg::SEQ_IDLE;
   logic [sdbts_pkg::POS_W-1:0]         position_q  = '0;
   logic [sdbts_pkg::IDX_W-1:0]         data_idx    = '0;
   logic [sdbts_pkg::ARG_W-1:0]         data_arg    = '0;
   logic [sdbts_pkg::FLAG_W-1:0]        data_flags  = '0;
   logic [sdbts_pkg::LEN_W-1:0]         data_blocks = '0;

   sd_block_transfer_sequencer u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_drive.req_type),
      .req_byte_position (req_drive.byte_position),
      .req_length_blocks (req_drive.length_blocks),
      .req_if_ok         (req_drive.if_ok),
      .req_card_state    (req_drive.card_state),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cmd_valid     (rsp_cmd_valid),
      .rsp_cmd_index     (rsp_cmd_index),
      .rsp_cmd_argument  (rsp_cmd_argument),
      .rsp_cmd_flags     (rsp_cmd_flags),
      .rsp_xfer_blocks   (rsp_xfer_blocks),
      .rsp_req_result    (rsp_req_result),
      .rsp_done_event    (rsp_done_event),
      .rsp_status        (rsp_status)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // fill in the command part of a result item
   function automatic sdbts_pkg::rsp_item_type put_cmd(
         input sdbts_pkg::rsp_item_type r,
         input logic [sdbts_pkg::IDX_W-1:0] idx,
         input logic [sdbts_pkg::ARG_W-1:0] arg,
         input logic [sdbts_pkg::FLAG_W-1:0] flags,
         input logic [sdbts_pkg::LEN_W-1:0] blocks);
      sdbts_pkg::rsp_item_type o;
      o = r;
      o.cmd_valid    = 1'b1;
      o.cmd_index    = idx;
      o.cmd_argument = arg;
      o.cmd_flags    = flags;
      o.xfer_blocks  = blocks;
      return o;
   endfunction

   // one sequencer step: updates the shadow state, returns the result item
   function automatic sdbts_pkg::rsp_item_type advance_sequencer(
         input sdbts_pkg::req_item_type it);
      sdbts_pkg::rsp_item_type      r;
      logic [sdbts_pkg::ARG_W-1:0]  rca_arg;
      logic [sdbts_pkg::FLAG_W-1:0] crc_bit;
      logic [sdbts_pkg::FLAG_W-1:0] flags;
      logic [sdbts_pkg::POS_W-1:0]  blk_pos;
      logic                         busy;
      logic                         wr;
      r = '0;
      r.req_result = sdbts_pkg::RES_NOT_REQ;
      rca_arg = {cfg_shadow.card_address, 16'h0000};
      crc_bit = cfg_shadow.crc_enable ? sdbts_pkg::FLAG_CRC : '0;
      busy = (seq_now != sdbts_pkg::SEQ_IDLE) && (seq_now != sdbts_pkg::SEQ_ERROR);
      case (it.req_type)
         sdbts_pkg::REQ_SET_POS: begin
            if (it.byte_position[BLK_SHIFT-1:0] != '0 ||
                (it.byte_position >> BLK_SHIFT) >=
                {{(sdbts_pkg::POS_W-sdbts_pkg::CNT_W){1'b0}}, cfg_shadow.block_count}) begin
               r.req_result = sdbts_pkg::RES_REJECTED;
            end else begin
               position_q = it.byte_position;
               r.req_result = sdbts_pkg::RES_ACCEPTED;
            end
         end
         sdbts_pkg::REQ_READ, sdbts_pkg::REQ_WRITE: begin
            wr = (it.req_type == sdbts_pkg::REQ_WRITE);
            if (it.length_blocks == '0) begin
               r.req_result = sdbts_pkg::RES_ZERO_LEN;
            end else if (busy || int'(it.length_blocks) > MAX_BLK) begin
               r.req_result = sdbts_pkg::RES_REJECTED;
            end else begin
               flags = sdbts_pkg::FLAG_DATA | crc_bit;
               if (wr) flags = flags | sdbts_pkg::FLAG_WRITE;
               if (it.length_blocks > 16'd1) flags = flags | sdbts_pkg::FLAG_AUTOSTOP;
               if (!cfg_shadow.spi_mode) flags = flags | sdbts_pkg::FLAG_SHORT;
               if (it.length_blocks == 16'd1) begin
                  data_idx = wr ? sdbts_pkg::CMD_WRITE_SINGLE : sdbts_pkg::CMD_READ_SINGLE;
               end else begin
                  data_idx = wr ? sdbts_pkg::CMD_WRITE_MULTI : sdbts_pkg::CMD_READ_MULTI;
               end
               // block addressing on high capacity cards, else low bits of the byte address
               blk_pos = cfg_shadow.high_capacity ? (position_q >> BLK_SHIFT) : position_q;
               data_arg    = blk_pos[sdbts_pkg::ARG_W-1:0];
               data_flags  = flags;
               data_blocks = it.length_blocks;
               r.req_result = sdbts_pkg::RES_ACCEPTED;
               if (!cfg_shadow.spi_mode) begin
                  seq_now = sdbts_pkg::SEQ_STATUS;
                  r = put_cmd(r, sdbts_pkg::CMD_STATUS, rca_arg,
                              sdbts_pkg::FLAG_WAITDATA | crc_bit | sdbts_pkg::FLAG_SHORT, '0);
               end else begin
                  seq_now = sdbts_pkg::SEQ_XFER;
                  r = put_cmd(r, data_idx, data_arg, data_flags, data_blocks);
               end
            end
         end
         sdbts_pkg::REQ_COMPLETE: begin
            case (seq_now)
               sdbts_pkg::SEQ_STATUS: begin
                  if (it.if_ok && it.card_state == sdbts_pkg::R1_TRAN) begin
                     seq_now = sdbts_pkg::SEQ_XFER;
                     r = put_cmd(r, data_idx, data_arg, data_flags, data_blocks);
                  end else if (it.if_ok && it.card_state == sdbts_pkg::R1_STBY) begin
                     seq_now = sdbts_pkg::SEQ_SELECT;
                     r = put_cmd(r, sdbts_pkg::CMD_SELECT, rca_arg,
                                 sdbts_pkg::FLAG_WAITDATA | crc_bit | sdbts_pkg::FLAG_SHORT,
                                 '0);
                  end else begin
                     seq_now = sdbts_pkg::SEQ_ERROR;
                     r.done_event = 1'b1;
                  end
               end
               // select outcome is not looked at
               sdbts_pkg::SEQ_SELECT: begin
                  seq_now = sdbts_pkg::SEQ_XFER;
                  r = put_cmd(r, data_idx, data_arg, data_flags, data_blocks);
               end
               sdbts_pkg::SEQ_XFER: begin
                  if (it.if_ok) begin
                     seq_now = sdbts_pkg::SEQ_IDLE;
                     r.done_event = 1'b1;
                  end else begin
                     seq_now = sdbts_pkg::SEQ_HALT;
                     r = put_cmd(r, sdbts_pkg::CMD_STOP, '0,
                                 sdbts_pkg::FLAG_STOP | crc_bit | sdbts_pkg::FLAG_SHORT, '0);
                  end
               end
               sdbts_pkg::SEQ_HALT: begin
                  seq_now = sdbts_pkg::SEQ_ERROR;
                  r.done_event = 1'b1;
               end
               default: ;
            endcase
         end
         sdbts_pkg::REQ_ISSUE_FAIL: begin
            if (busy) begin
               seq_now = sdbts_pkg::SEQ_ERROR;
               r.done_event = 1'b1;
            end
         end
         default: ;
      endcase
      case (seq_now)
         sdbts_pkg::SEQ_IDLE:  r.status = sdbts_pkg::STAT_IDLE;
         sdbts_pkg::SEQ_ERROR: r.status = sdbts_pkg::STAT_ERROR;
         default:              r.status = sdbts_pkg::STAT_BUSY;
      endcase
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin : req_driver
      logic                    next_valid;
      sdbts_pkg::req_item_type next_item;
      next_valid = req_valid;
      next_item  = req_drive;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seq_outcomes.push_back(advance_sequencer(req_drive));
            items_accepted++;
            next_valid = 1'b0;
         end
         if (!next_valid && req_backlog.size() != 0 &&
             $urandom_range(0, 99) >= send_gap_pct) begin
            next_item  = req_backlog.pop_front();
            next_valid = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_drive <= next_item;
   end

   // result monitor and receiver stall
   always @(posedge clock) begin : rsp_monitor
      sdbts_pkg::rsp_item_type got;
      sdbts_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_cmd_valid, rsp_cmd_index, rsp_cmd_argument, rsp_cmd_flags,
                rsp_xfer_blocks, rsp_req_result, rsp_done_event, rsp_status};
         if (seq_outcomes.size() == 0) begin
            $error("result item with nothing expected: 'h%0h", got);
            fail_count++;
         end else begin
            want = seq_outcomes.pop_front();
            check_field("cmd_valid", 32'(want.cmd_valid), 32'(got.cmd_valid));
            check_field("cmd_index", 32'(want.cmd_index), 32'(got.cmd_index));
            check_field("cmd_argument", want.cmd_argument, got.cmd_argument);
            check_field("cmd_flags", 32'(want.cmd_flags), 32'(got.cmd_flags));
            check_field("xfer_blocks", 32'(want.xfer_blocks), 32'(got.xfer_blocks));
            check_field("req_result", 32'(want.req_result), 32'(got.req_result));
            check_field("done_event", 32'(want.done_event), 32'(got.done_event));
            check_field("status", 32'(want.status), 32'(got.status));
         end
      end
      // long hold-off on request, else random stalls
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("sd_block_transfer_sequencer_test failed");
         $finish;
      end
   end

   task automatic queue_item(input sdbts_pkg::req_item_type it);
      req_backlog.push_back(it);
      items_queued++;
   endtask

   task automatic queue_req(input logic [2:0] kind, input logic [sdbts_pkg::POS_W-1:0] pos,
                            input logic [sdbts_pkg::LEN_W-1:0] len, input logic ok,
                            input logic [3:0] cs);
      sdbts_pkg::req_item_type it;
      it.req_type      = kind;
      it.byte_position = pos;
      it.length_blocks = len;
      it.if_ok         = ok;
      it.card_state    = cs;
      queue_item(it);
   endtask

   function automatic sdbts_pkg::req_item_type random_item();
      sdbts_pkg::req_item_type it;
      it.req_type                             = 3'($urandom_range(0, 7));
      it.byte_position[sdbts_pkg::POS_W-1:32] = 9'($urandom_range(0, 511));
      it.byte_position[31:0]                  = $urandom;
      it.length_blocks                        = 16'($urandom_range(0, 65535));
      it.if_ok                                = 1'($urandom_range(0, 1));
      it.card_state                           = 4'($urandom_range(0, 15));
      return it;
   endfunction

   // mostly in-range block positions, some at or past the end, some unaligned
   function automatic logic [sdbts_pkg::POS_W-1:0] pick_position();
      logic [sdbts_pkg::POS_W-1:0] p;
      logic [sdbts_pkg::POS_W-1:0] blk;
      int roll;
      roll = $urandom_range(0, 99);
      blk = '0;
      if (roll < 70 && cfg_shadow.block_count != '0) begin
         blk[31:0] = $urandom % cfg_shadow.block_count;
      end else if (roll < 85) begin
         blk = {{(sdbts_pkg::POS_W-sdbts_pkg::CNT_W){1'b0}}, cfg_shadow.block_count} +
               41'($urandom_range(0, 3));
      end else begin
         p[sdbts_pkg::POS_W-1:32] = 9'($urandom_range(0, 511));
         p[31:0]                  = $urandom;
         return p;
      end
      p = blk << BLK_SHIFT;
      return p;
   endfunction

   // lengths mostly short, a few anywhere in range
   function automatic logic [sdbts_pkg::LEN_W-1:0] pick_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return '0;
      if (roll < 70) return 16'($urandom_range(1, 4));
      if (roll < 94) return 16'($urandom_range(5, 300));
      return 16'($urandom_range(1, 65535));
   endfunction

   // one well-formed transfer with random content and random outcome
   task automatic queue_transfer();
      sdbts_pkg::req_item_type it;
      logic [3:0]              cs;
      int                      roll;
      if ($urandom_range(0, 2) == 0) begin
         it = random_item();
         it.req_type = sdbts_pkg::REQ_SET_POS;
         it.byte_position = pick_position();
         queue_item(it);
      end
      it = random_item();
      it.req_type = $urandom_range(0, 1) ? sdbts_pkg::REQ_WRITE : sdbts_pkg::REQ_READ;
      it.length_blocks = pick_length();
      queue_item(it);
      if (it.length_blocks == '0) return;
      if (!cfg_shadow.spi_mode) begin
         roll = $urandom_range(0, 99);
         it = random_item();
         it.req_type = sdbts_pkg::REQ_COMPLETE;
         it.if_ok = 1'b1;
         if (roll < 8) begin
            // status step fails: bus error or card in an unexpected state
            if ($urandom_range(0, 1) == 0) begin
               it.if_ok = 1'b0;
            end else begin
               do cs = 4'($urandom_range(0, 15));
               while (cs == sdbts_pkg::R1_STBY || cs == sdbts_pkg::R1_TRAN);
               it.card_state = cs;
            end
            queue_item(it);
            return;
         end
         it.card_state = (roll < 40) ? sdbts_pkg::R1_STBY : sdbts_pkg::R1_TRAN;
         queue_item(it);
         if (roll < 40) begin
            it = random_item();
            it.req_type = sdbts_pkg::REQ_COMPLETE;
            queue_item(it);
         end
      end
      roll = $urandom_range(0, 99);
      it = random_item();
      if (roll < 6) begin
         it.req_type = sdbts_pkg::REQ_ISSUE_FAIL;
         queue_item(it);
         return;
      end
      it.req_type = sdbts_pkg::REQ_COMPLETE;
      it.if_ok = (roll < 85);
      queue_item(it);
      if (!it.if_ok) begin
         it = random_item();
         it.req_type = sdbts_pkg::REQ_COMPLETE;
         queue_item(it);
      end
   endtask

   task automatic queue_mixed(input int count);
      sdbts_pkg::req_item_type it;
      int                      target;
      target = items_queued + count;
      while (items_queued < target) begin
         if ($urandom_range(0, 99) < 15) begin
            queue_item(random_item());
         end else begin
            queue_transfer();
         end
      end
      // leave the sequencer out of its busy states before settings change
      it = random_item();
      it.req_type = sdbts_pkg::REQ_ISSUE_FAIL;
      queue_item(it);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic apply_settings(input logic [sdbts_pkg::RCA_W-1:0] addr, input logic hc,
                                 input logic crc, input logic spi,
                                 input logic [sdbts_pkg::CNT_W-1:0] cnt);
      write_reg(sdbts_pkg::CSR_CARD_ADDRESS, {16'h0000, addr});
      write_reg(sdbts_pkg::CSR_HIGH_CAPACITY, {31'd0, hc});
      write_reg(sdbts_pkg::CSR_CRC_ENABLE, {31'd0, crc});
      write_reg(sdbts_pkg::CSR_SPI_MODE, {31'd0, spi});
      write_reg(sdbts_pkg::CSR_BLOCK_COUNT, cnt);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_shadow.card_address  = addr;
      cfg_shadow.high_capacity = hc;
      cfg_shadow.crc_enable    = crc;
      cfg_shadow.spi_mode      = spi;
      cfg_shadow.block_count   = cnt;
   endtask

   // wait for every queued item to go in and every result to come out
   task automatic drain();
      wait (items_accepted == items_queued);
      wait (seq_outcomes.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme address and count, status, select, data and stop command paths
      apply_settings(16'hFFFF, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
      queue_req(sdbts_pkg::REQ_SET_POS, 41'h0, 16'h0, 1'b0, 4'h0);
      queue_req(sdbts_pkg::REQ_SET_POS, 41'h1FF_FFFF_FE00, 16'hFFFF, 1'b1, 4'hF);
      queue_req(sdbts_pkg::REQ_SET_POS, 41'h000_0000_01FF, 16'h0, 1'b0, 4'h0);
      // wide byte address, only the low bits reach the argument
      queue_req(sdbts_pkg::REQ_SET_POS, 41'h1FF_FFFF_FC00, 16'h0, 1'b1, 4'h0);
      queue_req(sdbts_pkg::REQ_READ, 41'h0, 16'h0, 1'b0, 4'h0);
      queue_req(sdbts_pkg::REQ_READ, 41'h1FF_FFFF_FFFF, 16'd1, 1'b0, 4'h0);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b1, sdbts_pkg::R1_TRAN);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b1, 4'hF);
      queue_req(sdbts_pkg::REQ_WRITE, 41'h0, 16'hFFFF, 1'b1, 4'h0);
      // read while busy is turned away, set position still goes through
      queue_req(sdbts_pkg::REQ_READ, 41'h0, 16'd3, 1'b1, 4'h0);
      queue_req(sdbts_pkg::REQ_SET_POS, 41'h200, 16'h0, 1'b0, 4'h0);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b1, sdbts_pkg::R1_STBY);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b0, 4'h0);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b0, 4'h0);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b1, 4'h0);
      // restart from error, then status failures by card state and by bus
      queue_req(sdbts_pkg::REQ_READ, 41'h0, 16'd2, 1'b1, 4'h0);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b1, 4'd9);
      queue_req(sdbts_pkg::REQ_WRITE, 41'h0, 16'd1, 1'b1, 4'h0);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b0, sdbts_pkg::R1_TRAN);
      // issue failure while busy, then ignored in error
      queue_req(sdbts_pkg::REQ_READ, 41'h0, 16'd1, 1'b1, 4'h0);
      queue_req(sdbts_pkg::REQ_ISSUE_FAIL, 41'h0, 16'h0, 1'b1, 4'h0);
      queue_req(sdbts_pkg::REQ_ISSUE_FAIL, 41'h0, 16'h0, 1'b1, 4'h0);
      queue_req(sdbts_pkg::REQ_COMPLETE, 41'h0, 16'h0, 1'b1, sdbts_pkg::R1_TRAN);
      queue_req(3'd5, 41'h1FF_FFFF_FFFF, 16'hFFFF, 1'b1, 4'hF);
      queue_req(3'd7, 41'h0, 16'h0, 1'b0, 4'h0);
      drain();

      // block addressing, small card
      apply_settings(16'h0000, 1'b1, 1'b0, 1'b0, 32'd1000);
      queue_mixed(PHASE_ITEMS);
      drain();

      // spi bus with an empty card, receiver holds off for a long stretch
      apply_settings(16'h1234, 1'b0, 1'b1, 1'b1, 32'd0);
      hold_requests++;
      queue_mixed(PHASE_ITEMS);
      drain();

      // random settings, no idling on either side
      apply_settings(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
      send_gap_pct = 0;
      stall_pct = 0;
      queue_mixed(PHASE_ITEMS);
      drain();
      send_gap_pct = 15;
      stall_pct = 15;

      // full size high capacity card
      apply_settings(16'($urandom_range(0, 65535)), 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF);
      queue_mixed(PHASE_ITEMS);
      drain();

      // spi bus, block addressing, single block card
      apply_settings(16'hFFFF, 1'b1, 1'b0, 1'b1, 32'd1);
      queue_mixed(PHASE_ITEMS);
      drain();

      if (fail_count == 0) begin
         $display("sd_block_transfer_sequencer_test passed");
      end else begin
         $display("sd_block_transfer_sequencer_test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/sdbts_pkg.sv
rtl/sdbts_seq.sv
rtl/sd_block_transfer_sequencer.sv
tb/sv/sd_block_transfer_sequencer_test.sv
